>>> rtl/rsti_pkg.sv
// ----------------------------------------------------------------------------
// rsti_pkg: shared types and constants for the radix string-to-integer parser
// Holds the item structs, the parse phase enum and the character decode.
// ----------------------------------------------------------------------------
`default_nettype none

package rsti_pkg;

   // Characters taken into the parse per string; later ones are ignored.
   localparam logic [31:0] MAX_LENGTH = 32'd65535;

   // Digit code for a character that is no digit in any base.
   localparam logic [5:0] NO_DIGIT = 6'd36;

   // Bases with special meaning.
   localparam logic [5:0] BASE_AUTO = 6'd0;
   localparam logic [5:0] BASE_2    = 6'd2;
   localparam logic [5:0] BASE_8    = 6'd8;
   localparam logic [5:0] BASE_10   = 6'd10;
   localparam logic [5:0] BASE_16   = 6'd16;

   // ASCII codes the parser reacts to.
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;
   localparam logic [7:0] CHAR_LO_B  = 8'h62;
   localparam logic [7:0] CHAR_UP_B  = 8'h42;

   // Counter saturation value.
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // Parse phases of one string.
   typedef enum logic [1:0] {
      PH_SIGN,
      PH_ZERO,
      PH_DIGITS,
      PH_STOPPED
   } phase_type;

   // One input item: a character of the string.
   typedef struct packed {
      logic [7:0] character;
      logic       has_char;
      logic       last;
   } req_item_type;

   // One result item: the parsed integer and its bookkeeping.
   typedef struct packed {
      logic signed [63:0] value;
      logic [15:0]        consumed;
      logic [5:0]         base_used;
      logic               overflow;
   } rsp_item_type;

   // Digit value of an ASCII character, either letter case, or NO_DIGIT.
   function automatic logic [5:0] digit_value(input logic [7:0] c);
      logic [5:0] d;
      d = NO_DIGIT;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = 6'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         d = 6'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = 6'(c - 8'h61 + 8'd10);
      end
      return d;
   endfunction

endpackage

`default_nettype wire

>>> rtl/radix_string_to_integer.sv
// ----------------------------------------------------------------------------
// radix_string_to_integer: streaming signed integer parser
// Parses one character per item with sign run, base prefix and digits, and
// gives one result item on the item that ends the string.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  req      in         req_valid/stall    rsti_pkg::req_item_type (character)
//  rsp      out        rsp_valid/stall    rsti_pkg::rsp_item_type (result)
//  csr      in         csr_valid/ready    radix, 6 bits
//
// One item is accepted every cycle unless req_stall is raised. An accepted item
// sits in an input register, where one multiply-add of the 64-bit accumulator by the
// 6-bit base updates the parse state; a result item is valid once the item ending
// its string has moved from the input register into the result register.
// Reset clears the parse state, the radix and both valid flags. While the
// result register is full and stalled, an item that ends a string waits in
// the input register and req_stall is raised; other items keep flowing.
//
`default_nettype none

module radix_string_to_integer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire rsti_pkg::req_item_type req_item,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      rsti_pkg::rsp_item_type rsp_item,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [5:0]            csr_data
);

   // Configuration register.
   logic [5:0] radix_ff;

   // Input register.
   logic                   in_valid_ff;
   rsti_pkg::req_item_type in_item_ff;

   // Parse state.
   rsti_pkg::phase_type phase_ff, phase_in;
   logic [63:0]         acc_ff, acc_in;
   logic                neg_ff, neg_in;
   logic [5:0]          abase_ff, abase_in;
   logic [15:0]         consumed_ff, consumed_in;
   logic [15:0]         pending_ff, pending_in;
   logic                ovf_ff, ovf_in;

   // Result register.
   logic                   out_valid_ff;
   rsti_pkg::rsp_item_type out_item_ff, out_item_in;

   logic        out_free;
   logic        advance;
   logic        take;
   logic [7:0]  c;
   logic [5:0]  d;
   logic [5:0]  mul_base;
   logic [70:0] prod;
   logic [15:0] consumed_inc;
   logic [5:0]  final_base;
   logic        is_x;
   logic        is_b;

   // Handshakes: the item in the input register moves on unless it needs the
   // result register and that is still held.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_item_ff.last || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // Character decode shared by all phases.
   assign c    = in_item_ff.character;
   assign d    = rsti_pkg::digit_value(c);
   assign is_x = (c == rsti_pkg::CHAR_LO_X) || (c == rsti_pkg::CHAR_UP_X);
   assign is_b = (c == rsti_pkg::CHAR_LO_B) || (c == rsti_pkg::CHAR_UP_B);
   assign take = in_item_ff.has_char && ({16'd0, pending_ff} < rsti_pkg::MAX_LENGTH);
   assign consumed_inc = (consumed_ff == rsti_pkg::COUNT_MAX) ? consumed_ff
                                                              : consumed_ff + 16'd1;

   // Base for the multiply-add: in the sign phase it comes from the radix, 10 if auto.
   always_comb begin
      if (phase_ff == rsti_pkg::PH_SIGN) begin
         mul_base = (radix_ff == rsti_pkg::BASE_AUTO) ? rsti_pkg::BASE_10 : radix_ff;
      end else begin
         mul_base = abase_ff;
      end
   end

   // One multiply-add; any bit above the low 64 bits marks a wrap.
   assign prod = 71'(acc_ff) * 71'(mul_base) + 71'(d);

   // Parse step for one character.
   always_comb begin
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      abase_in    = abase_ff;
      consumed_in = consumed_ff;
      pending_in  = pending_ff;
      ovf_in      = ovf_ff;
      out_item_in = out_item_ff;

      if (take) begin
         pending_in = (pending_ff == rsti_pkg::COUNT_MAX) ? pending_ff : pending_ff + 16'd1;
         case (phase_ff)
            rsti_pkg::PH_SIGN: begin
               if (c == rsti_pkg::CHAR_MINUS) begin
                  neg_in      = !neg_ff;
                  consumed_in = consumed_inc;
               end else if (c == rsti_pkg::CHAR_PLUS) begin
                  consumed_in = consumed_inc;
               end else if (radix_ff == rsti_pkg::BASE_AUTO && c == rsti_pkg::CHAR_ZERO) begin
                  abase_in    = rsti_pkg::BASE_8;
                  consumed_in = consumed_inc;
                  phase_in    = rsti_pkg::PH_ZERO;
               end else begin
                  abase_in = mul_base;
                  if (d == rsti_pkg::NO_DIGIT || d >= mul_base) begin
                     phase_in = rsti_pkg::PH_STOPPED;
                  end else begin
                     acc_in      = prod[63:0];
                     ovf_in      = ovf_ff | (|prod[70:64]);
                     consumed_in = consumed_inc;
                     phase_in    = rsti_pkg::PH_DIGITS;
                     // A leading zero under an explicit base 16 or 2 may open a prefix.
                     if ((radix_ff == rsti_pkg::BASE_16 || radix_ff == rsti_pkg::BASE_2)
                         && c == rsti_pkg::CHAR_ZERO) begin
                        phase_in = rsti_pkg::PH_ZERO;
                     end
                  end
               end
            end
            rsti_pkg::PH_ZERO: begin
               phase_in = rsti_pkg::PH_DIGITS;
               if (abase_ff == rsti_pkg::BASE_8 && is_x) begin
                  abase_in    = rsti_pkg::BASE_16;
                  consumed_in = consumed_inc;
               end else if (abase_ff == rsti_pkg::BASE_8 && is_b) begin
                  abase_in    = rsti_pkg::BASE_2;
                  consumed_in = consumed_inc;
               end else if ((abase_ff == rsti_pkg::BASE_16 && is_x)
                            || (abase_ff == rsti_pkg::BASE_2 && is_b)) begin
                  consumed_in = consumed_inc;
               end else if (d == rsti_pkg::NO_DIGIT || d >= abase_ff) begin
                  phase_in = rsti_pkg::PH_STOPPED;
               end else begin
                  acc_in      = prod[63:0];
                  ovf_in      = ovf_ff | (|prod[70:64]);
                  consumed_in = consumed_inc;
               end
            end
            rsti_pkg::PH_DIGITS: begin
               if (d == rsti_pkg::NO_DIGIT || d >= abase_ff) begin
                  phase_in = rsti_pkg::PH_STOPPED;
               end else begin
                  acc_in      = prod[63:0];
                  ovf_in      = ovf_ff | (|prod[70:64]);
                  consumed_in = consumed_inc;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      // Base reported for the string, from the state after this item.
      if (phase_in == rsti_pkg::PH_SIGN) begin
         final_base = (radix_ff == rsti_pkg::BASE_AUTO) ? rsti_pkg::BASE_10 : radix_ff;
      end else begin
         final_base = abase_in;
      end

      // The item that ends a string loads the result and clears the parse.
      if (in_item_ff.last) begin
         out_item_in.value     = neg_in ? $signed(64'd0 - acc_in) : $signed(acc_in);
         out_item_in.consumed  = consumed_in;
         out_item_in.base_used = final_base;
         out_item_in.overflow  = ovf_in;
         phase_in    = rsti_pkg::PH_SIGN;
         acc_in      = 64'd0;
         neg_in      = 1'b0;
         abase_in    = 6'd0;
         consumed_in = 16'd0;
         pending_in  = 16'd0;
         ovf_in      = 1'b0;
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= rsti_pkg::BASE_AUTO;
      end else if (csr_valid && csr_ready) begin
         radix_ff <= csr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_item;
      end
   end

   // Parse state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= rsti_pkg::PH_SIGN;
         acc_ff      <= 64'd0;
         neg_ff      <= 1'b0;
         abase_ff    <= 6'd0;
         consumed_ff <= 16'd0;
         pending_ff  <= 16'd0;
         ovf_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         acc_ff      <= acc_in;
         neg_ff      <= neg_in;
         abase_ff    <= abase_in;
         consumed_ff <= consumed_in;
         pending_ff  <= pending_in;
         ovf_ff      <= ovf_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_item_ff.last) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_item_ff.last) begin
         out_item_ff <= out_item_in;
      end
   end

endmodule

`default_nettype wire
